[hdl/tacs_pkg.sv]
package tacs_pkg;

    localparam int unsigned OPW = 2;
    localparam int unsigned FNW = 4;
    localparam int unsigned STW = 3;

    typedef enum logic [1:0] {
        OP_NOP = 2'd0,
        OP_CMP = 2'd1,
        OP_UNA = 2'd2,
        OP_BIN = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        FLAG_NONE = 2'd0,
        FLAG_SKIP = 2'd1,
        FLAG_RUN  = 2'd2
    } flag_t;

    localparam logic [STW-1:0] ST_OK      = 3'd0;
    localparam logic [STW-1:0] ST_SKIPPED = 3'd1;
    localparam logic [STW-1:0] ST_TYPE    = 3'd2;
    localparam logic [STW-1:0] ST_DIVZERO = 3'd3;
    localparam logic [STW-1:0] ST_UNSUP   = 3'd4;

    // Compare functions.
    localparam logic [FNW-1:0] CMP_EQ = 4'd0;
    localparam logic [FNW-1:0] CMP_NE = 4'd1;
    localparam logic [FNW-1:0] CMP_LT = 4'd2;
    localparam logic [FNW-1:0] CMP_GT = 4'd3;
    localparam logic [FNW-1:0] CMP_LE = 4'd4;
    localparam logic [FNW-1:0] CMP_GE = 4'd5;

    // Unary functions.
    localparam logic [FNW-1:0] UN_INC = 4'd0;
    localparam logic [FNW-1:0] UN_DEC = 4'd1;
    localparam logic [FNW-1:0] UN_NOT = 4'd2;
    localparam logic [FNW-1:0] UN_NEG = 4'd3;
    localparam logic [FNW-1:0] UN_ID  = 4'd4;

    // Binary functions.
    localparam logic [FNW-1:0] BI_ADD = 4'd0;
    localparam logic [FNW-1:0] BI_SUB = 4'd1;
    localparam logic [FNW-1:0] BI_MUL = 4'd2;
    localparam logic [FNW-1:0] BI_DIV = 4'd3;
    localparam logic [FNW-1:0] BI_MOD = 4'd4;
    localparam logic [FNW-1:0] BI_SHL = 4'd5;
    localparam logic [FNW-1:0] BI_SHR = 4'd6;
    localparam logic [FNW-1:0] BI_AND = 4'd7;
    localparam logic [FNW-1:0] BI_OR  = 4'd8;
    localparam logic [FNW-1:0] BI_XOR = 4'd9;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture operands and decode
        logic iter;     // one multiply or divide step
        logic finish;   // form the result word
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_iter;  // item uses the multi-cycle unit
        logic iter_last;   // the current step is the final one
    } dp_stat_t;

endpackage

[hdl/tacs_in_if.sv]
interface tacs_in_if #(
    parameter int unsigned DATA_WIDTH = 64
);
    logic            valid;
    logic            ready;
    logic [1:0]      op;
    logic [3:0]      func;
    logic            a_signed;
    logic            b_signed;
    logic [63:0]     operand_a;
    logic [63:0]     operand_b;

    modport source (output valid, op, func, a_signed, b_signed, operand_a, operand_b,
                    input ready);
    modport sink   (input valid, op, func, a_signed, b_signed, operand_a, operand_b,
                    output ready);
endinterface

[hdl/tacs_out_if.sv]
interface tacs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_value;
    logic [2:0]  status;
    logic        cond_true;

    modport source (output valid, result_value, status, cond_true, input ready);
    modport sink   (input valid, result_value, status, cond_true, output ready);
endinterface

[hdl/typed_alu_with_condition_skip.sv]
// Typed integer ALU with condition skip.
// Channel in: one beat per instruction (op, func, operand types, two operands).
// Channel out: one beat per instruction (result_value, status, cond_true).
// Both channels use a valid/ready handshake; a beat moves when both are high.
// An accepted instruction passes a decode and a finish state, the latter
// loading its result beat; multiply, divide and modulo of matching types,
// unless skipped, first run one bit a cycle through a shared shift-add /
// restoring divide unit. One instruction is in flight at a time; the next
// can be taken the cycle after the prior result enters the output register.
// Compares arm a skip flag held between instructions: a false condition
// skips the next instruction, a true one runs it and skips the one after,
// unless the one run is a compare or fails. Reset clears the flag and the
// output valid, and the block returns to idle. If the receiver stalls, the
// finished result waits in the output register; one further instruction can
// be accepted and computed, then waits for the register to be free to finish.
module typed_alu_with_condition_skip #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input logic            clk,
    input logic            rst_n,
    tacs_in_if.sink        in_ch,
    tacs_out_if.source     out_ch
);
    import tacs_pkg::*;

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic [1:0] flag, flag_out;

    tacs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd),
        .flag_out  (flag_out),
        .flag      (flag)
    );

    tacs_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .stat         (stat),
        .op           (in_ch.op),
        .func         (in_ch.func),
        .a_signed     (in_ch.a_signed),
        .b_signed     (in_ch.b_signed),
        .operand_a    (in_ch.operand_a),
        .operand_b    (in_ch.operand_b),
        .flag_in      (flag),
        .flag_out     (flag_out),
        .result_value (out_ch.result_value),
        .status       (out_ch.status),
        .cond_true    (out_ch.cond_true)
    );

    // A stalled result beat must stay valid with its status unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
        else $error("result beat changed while stalled");

    // The skip flag never holds an undefined code.
    a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
        flag != 2'd3)
        else $error("skip flag has an invalid code");

    // The load and finish commands never coincide.
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.finish))
        else $error("load and finish issued together");

    // cond_true is only reported with an executed status.
    a_cond_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.cond_true |-> out_ch.status == ST_OK)
        else $error("cond_true with a non-executed status");

endmodule

[hdl/tacs_datapath.sv]
module tacs_datapath #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                  clk,
    input  tacs_pkg::dp_cmd_t     cmd,
    output tacs_pkg::dp_stat_t    stat,
    input  logic [1:0]            op,
    input  logic [3:0]            func,
    input  logic                  a_signed,
    input  logic                  b_signed,
    input  logic [63:0]           operand_a,
    input  logic [63:0]           operand_b,
    input  logic [1:0]            flag_in,
    output logic [1:0]            flag_out,
    output logic [63:0]           result_value,
    output logic [2:0]            status,
    output logic                  cond_true
);
    import tacs_pkg::*;

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned CW = $clog2(W + 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

    // Captured item.
    logic [1:0]   op_reg;
    logic [3:0]   fn_reg;
    logic         sa_reg, sb_reg;
    logic [W-1:0] a_reg, b_reg;
    logic         skipped_reg;

    // Multi-cycle unit: shared by multiply and divide.
    logic [W-1:0]  acc_reg, acc_next;   // product or remainder
    logic [W-1:0]  q_reg, q_next;       // multiplier bits or quotient
    logic [W-1:0]  dv_reg;              // multiplicand or divisor magnitude
    logic [CW-1:0] cnt_reg;

    logic         is_mul, is_div, na, nb;
    logic [W-1:0] ma, mb;
    logic [W:0]   trial;

    assign na = a_signed & operand_a[W-1];
    assign nb = b_signed & operand_b[W-1];
    assign ma = na ? (W'(0) - operand_a[W-1:0]) : operand_a[W-1:0];
    assign mb = nb ? (W'(0) - operand_b[W-1:0]) : operand_b[W-1:0];
    assign is_mul = (op_reg == OP_BIN) && (fn_reg == BI_MUL);
    assign is_div = (op_reg == OP_BIN) && ((fn_reg == BI_DIV) || (fn_reg == BI_MOD));

    assign stat.needs_iter = (is_mul || is_div) && (sa_reg == sb_reg) && !skipped_reg;
    assign stat.iter_last  = (cnt_reg == LAST_STEP);

    // One shift-add or restoring-divide step per cycle.
    always_comb
    begin
        acc_next = acc_reg;
        q_next   = q_reg;
        trial    = '0;
        if (is_mul)
        begin
            acc_next = q_reg[W-1] ? ((acc_reg << 1) + dv_reg) : (acc_reg << 1);
            q_next   = q_reg << 1;
        end
        else
        begin
            trial = {acc_reg, q_reg[W-1]} - {1'b0, dv_reg};
            if (!trial[W])
            begin
                acc_next = trial[W-1:0];
                q_next   = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                acc_next = {acc_reg[W-2:0], q_reg[W-1]};
                q_next   = {q_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op;
            fn_reg      <= func;
            sa_reg      <= a_signed;
            sb_reg      <= b_signed;
            a_reg       <= operand_a[W-1:0];
            b_reg       <= operand_b[W-1:0];
            skipped_reg <= (flag_in == FLAG_SKIP);
            acc_reg     <= '0;
            cnt_reg     <= '0;
            if ((op == OP_BIN) && (func == BI_MUL))
            begin
                q_reg  <= operand_b[W-1:0];
                dv_reg <= operand_a[W-1:0];
            end
            else
            begin
                q_reg  <= ma;
                dv_reg <= mb;
            end
        end
        else if (cmd.iter)
        begin
            acc_reg <= acc_next;
            q_reg   <= q_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Result formation from the captured item.
    logic [W-1:0] val, shr;
    logic [2:0]   st;
    logic         holds, neg_a, big_sh;
    logic [W-1:0] xa, yb;
    logic [1:0]   fl;

    always_comb
    begin
        val    = '0;
        st     = ST_OK;
        holds  = 1'b0;
        neg_a  = sa_reg & a_reg[W-1];
        big_sh = (b_reg >= W'(W));
        xa     = sa_reg ? (a_reg ^ {1'b1, {(W-1){1'b0}}}) : a_reg;
        yb     = sa_reg ? (b_reg ^ {1'b1, {(W-1){1'b0}}}) : b_reg;
        shr    = big_sh ? {W{neg_a}} : W'($signed({neg_a, a_reg}) >>> b_reg);
        fl     = (flag_in == FLAG_RUN) ? FLAG_SKIP : FLAG_NONE;
        case (op_reg)
            OP_CMP:
            begin
                if (sa_reg != sb_reg)
                    st = ST_TYPE;
                else
                begin
                    case (fn_reg)
                        CMP_EQ:  holds = (xa == yb);
                        CMP_NE:  holds = (xa != yb);
                        CMP_LT:  holds = (xa < yb);
                        CMP_GT:  holds = (xa > yb);
                        CMP_LE:  holds = (xa <= yb);
                        CMP_GE:  holds = (xa >= yb);
                        default: st = ST_UNSUP;
                    endcase
                end
                if (st == ST_OK)
                    fl = holds ? FLAG_RUN : FLAG_SKIP;
            end
            OP_UNA:
            begin
                case (fn_reg)
                    UN_INC:  val = a_reg + 1'b1;
                    UN_DEC:  val = a_reg - 1'b1;
                    UN_NOT:  val = ~a_reg;
                    UN_NEG:
                    begin
                        if (!sa_reg)
                            st = ST_TYPE;
                        else
                            val = W'(0) - a_reg;
                    end
                    UN_ID:   val = a_reg;
                    default: st = ST_UNSUP;
                endcase
            end
            OP_BIN:
            begin
                if (fn_reg > BI_XOR)
                    st = ST_UNSUP;
                else if (sa_reg != sb_reg)
                    st = ST_TYPE;
                else
                begin
                    case (fn_reg)
                        BI_ADD: val = a_reg + b_reg;
                        BI_SUB: val = a_reg - b_reg;
                        BI_MUL: val = acc_reg;
                        BI_DIV:
                        begin
                            if (b_reg == '0)
                                st = ST_DIVZERO;
                            else if (sa_reg && (a_reg[W-1] != b_reg[W-1]))
                                val = W'(0) - q_reg;
                            else
                                val = q_reg;
                        end
                        BI_MOD:
                        begin
                            if (b_reg == '0)
                                st = ST_DIVZERO;
                            else if (neg_a)
                                val = W'(0) - acc_reg;
                            else
                                val = acc_reg;
                        end
                        BI_SHL: val = big_sh ? '0 : (a_reg << b_reg);
                        BI_SHR: val = shr;
                        BI_AND: val = a_reg & b_reg;
                        BI_OR:  val = a_reg | b_reg;
                        default: val = a_reg ^ b_reg;
                    endcase
                end
            end
            default: ;
        endcase
        if (st != ST_OK)
        begin
            fl    = FLAG_NONE;
            val   = '0;
            holds = 1'b0;
        end
        if (skipped_reg)
        begin
            fl    = FLAG_NONE;
            val   = '0;
            holds = 1'b0;
            st    = ST_SKIPPED;
        end
    end

    // Output register, loaded at the end of an item.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_value <= 64'(val);
            status       <= st;
            cond_true    <= holds && (op_reg == OP_CMP);
        end
    end

    assign flag_out = fl;

endmodule

[hdl/tacs_ctrl.sv]
module tacs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  tacs_pkg::dp_stat_t stat,
    output tacs_pkg::dp_cmd_t  cmd,
    input  logic [1:0]         flag_out,
    output logic [1:0]         flag
);
    import tacs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEC  = 4'b0010,
        S_ITER = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic [1:0] flag_reg, flag_next;

    // The output register may still hold a beat when a new item is taken.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign flag      = flag_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        flag_next      = flag_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
                state_next = stat.needs_iter ? S_ITER : S_FIN;
            S_ITER:
            begin
                cmd.iter = 1'b1;
                if (stat.iter_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    flag_next      = flag_out;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            flag_reg      <= FLAG_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            flag_reg      <= flag_next;
        end
    end

endmodule

[verif/tb_tacs_channels.sv]
`timescale 1ns / 1ps

// The block's channel interfaces come with the RTL; this file carries the
// testbench-side beat records shared by the stimulus and the checker.
package tb_tacs_beats_pkg;

    import tacs_pkg::*;

    // One instruction beat as offered on the input channel.
    typedef struct {
        op_t         op;
        logic [3:0]  func;
        logic        a_signed;
        logic        b_signed;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } instr_t;

    // One result beat as expected on the output channel.
    typedef struct {
        logic [63:0] result_value;
        logic [2:0]  status;
        logic        cond_true;
    } outcome_t;

endpackage

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

    import tacs_pkg::*;
    import tb_tacs_beats_pkg::*;

    localparam int unsigned W = 64;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONES = '1;
    localparam int N_RANDOM = 1200;

    logic clk;
    logic rst_n;

    tacs_in_if #(.DATA_WIDTH(W)) in_ch ();
    tacs_out_if out_ch ();

    typed_alu_with_condition_skip #(.DATA_WIDTH(W)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Clock with a 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state and the queue of awaited result beats.
    flag_t    pred_flag;
    outcome_t awaited_results[$];
    int       fail_count;
    int       sent_count;
    bit       quiet_phase;
    bit       hold_off;
    bit       stim_done;

    // Directed table; a row with check set carries its result read off directly.
    typedef struct {
        instr_t   ins;
        bit       check;
        outcome_t res;
    } row_t;
    row_t directed[$];

    function automatic instr_t mk(op_t o, logic [3:0] f, logic sa, logic sb,
                                  logic [63:0] a, logic [63:0] b);
        instr_t i;
        i.op = o; i.func = f; i.a_signed = sa; i.b_signed = sb;
        i.operand_a = a; i.operand_b = b;
        return i;
    endfunction

    function automatic logic [63:0] shift_right_fill(logic sgn, logic [63:0] a,
                                                     logic [63:0] n);
        logic neg;
        neg = sgn && a[63];
        if (n >= W)
            return neg ? ONES : '0;
        return neg ? (a >>> n) | ~(ONES >> n) : a >> n;
    endfunction

    // Work out the result of one instruction and advance the skip flag.
    function automatic outcome_t alu_predict(instr_t i);
        outcome_t r;
        logic holds;
        logic [63:0] a, b, ma, mb, q, m;
        logic [2:0] st;
        r.result_value = '0; r.status = ST_OK; r.cond_true = 1'b0;
        holds = 1'b0; st = ST_OK;
        a = i.operand_a; b = i.operand_b;
        if (pred_flag == FLAG_SKIP)
        begin
            pred_flag = FLAG_NONE;
            r.status = ST_SKIPPED;
            return r;
        end
        pred_flag = (pred_flag == FLAG_RUN) ? FLAG_SKIP : FLAG_NONE;
        case (i.op)
            OP_CMP:
            begin
                if (i.a_signed != i.b_signed)
                    st = ST_TYPE;
                else
                begin
                    if (i.a_signed)
                    begin
                        a[63] = ~a[63];
                        b[63] = ~b[63];
                    end
                    case (i.func)
                        CMP_EQ: holds = a == b;
                        CMP_NE: holds = a != b;
                        CMP_LT: holds = a < b;
                        CMP_GT: holds = a > b;
                        CMP_LE: holds = a <= b;
                        CMP_GE: holds = a >= b;
                        default: st = ST_UNSUP;
                    endcase
                    if (st == ST_OK)
                        pred_flag = holds ? FLAG_RUN : FLAG_SKIP;
                end
            end
            OP_UNA:
            begin
                case (i.func)
                    UN_INC: r.result_value = a + 1;
                    UN_DEC: r.result_value = a - 1;
                    UN_NOT: r.result_value = ~a;
                    UN_NEG:
                        if (!i.a_signed) st = ST_TYPE;
                        else r.result_value = -a;
                    UN_ID: r.result_value = a;
                    default: st = ST_UNSUP;
                endcase
            end
            OP_BIN:
            begin
                if (i.func > BI_XOR)
                    st = ST_UNSUP;
                else if (i.a_signed != i.b_signed)
                    st = ST_TYPE;
                else
                    case (i.func)
                        BI_ADD: r.result_value = a + b;
                        BI_SUB: r.result_value = a - b;
                        BI_MUL: r.result_value = a * b;
                        BI_DIV, BI_MOD:
                        begin
                            if (b == 0)
                                st = ST_DIVZERO;
                            else if (!i.a_signed)
                                r.result_value = (i.func == BI_MOD) ? a % b : a / b;
                            else
                            begin
                                // Magnitudes, then signs: truncation towards zero.
                                ma = a[63] ? -a : a;
                                mb = b[63] ? -b : b;
                                q = ma / mb;
                                m = ma % mb;
                                if (i.func == BI_MOD)
                                    r.result_value = a[63] ? -m : m;
                                else
                                    r.result_value = (a[63] != b[63]) ? -q : q;
                            end
                        end
                        BI_SHL: r.result_value = (b >= W) ? '0 : a << b;
                        BI_SHR: r.result_value = shift_right_fill(i.a_signed, a, b);
                        BI_AND: r.result_value = a & b;
                        BI_OR:  r.result_value = a | b;
                        default: r.result_value = a ^ b;
                    endcase
            end
            default: ;
        endcase
        if (st != ST_OK)
        begin
            pred_flag = FLAG_NONE;
            r.result_value = '0;
            holds = 1'b0;
        end
        r.status = st;
        r.cond_true = (i.op == OP_CMP) && holds;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = ONES;
            2: v = SMIN;
            3: v = ~SMIN;
            4: v = 64'($urandom_range(0, 70));
            5: v = -64'($urandom_range(1, 70));
            6: v = SMIN | 64'($urandom_range(0, 3));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic instr_t rand_instr();
        instr_t i;
        logic s;
        s = 1'($urandom_range(0, 1));
        i.op = op_t'($urandom_range(0, 3));
        // Mostly well-typed, in-range functions; some noise beyond.
        i.func = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                 : 4'($urandom_range(0, (i.op == OP_CMP) ? 5 : (i.op == OP_UNA) ? 4 : 9));
        i.a_signed = s;
        i.b_signed = ($urandom_range(0, 9) == 0) ? ~s : s;
        i.operand_a = rand64();
        i.operand_b = rand64();
        // Keep operands close now and then so that compares sometimes hold.
        if ($urandom_range(0, 3) == 0)
            i.operand_b = i.operand_a + $urandom_range(0, 2) - 1;
        return i;
    endfunction

    // Offer one beat and wait until it is taken; an expectation goes in at acceptance.
    task automatic send_beat(instr_t i, bit check, outcome_t res);
        outcome_t p;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= i.op;
        in_ch.func      <= i.func;
        in_ch.a_signed  <= i.a_signed;
        in_ch.b_signed  <= i.b_signed;
        in_ch.operand_a <= i.operand_a;
        in_ch.operand_b <= i.operand_b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        p = alu_predict(i);
        if (check)
        begin
            if (p.result_value !== res.result_value)
            begin
                $error("directed result_value expected %h actual %h",
                       res.result_value, p.result_value);
                fail_count++;
            end
            if (p.status !== res.status)
            begin
                $error("directed status expected %0d actual %0d", res.status, p.status);
                fail_count++;
            end
            if (p.cond_true !== res.cond_true)
            begin
                $error("directed cond_true expected %0b actual %0b",
                       res.cond_true, p.cond_true);
                fail_count++;
            end
        end
        awaited_results.push_back(p);
        sent_count++;
    endtask

    // Stimulus: reset, the directed table, then random instructions.
    initial
    begin
        outcome_t none;
        in_ch.valid <= 1'b0; in_ch.op <= OP_NOP; in_ch.func <= '0;
        in_ch.a_signed <= 1'b0; in_ch.b_signed <= 1'b0;
        in_ch.operand_a <= '0; in_ch.operand_b <= '0;
        pred_flag = FLAG_NONE; fail_count = 0; quiet_phase = 0; stim_done = 0;
        hold_off = 0; sent_count = 0;
        none = '{'0, ST_OK, 1'b0};
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        directed.push_back('{mk(OP_NOP, 0, 0, 0, '0, '0), 1, none});
        directed.push_back('{mk(OP_UNA, UN_INC, 0, 0, ONES, '0), 1, none});
        directed.push_back('{mk(OP_UNA, UN_NEG, 1, 1, SMIN, '0), 1, '{SMIN, ST_OK, 0}});
        directed.push_back('{mk(OP_UNA, UN_NEG, 0, 0, 5, '0), 1, '{'0, ST_TYPE, 0}});
        directed.push_back('{mk(OP_UNA, UN_NOT, 0, 0, '0, '0), 1, '{ONES, ST_OK, 0}});
        directed.push_back('{mk(OP_UNA, 4'd5, 1, 1, 1, '0), 1, '{'0, ST_UNSUP, 0}});
        directed.push_back('{mk(OP_BIN, BI_DIV, 1, 1, SMIN, ONES), 1, '{SMIN, ST_OK, 0}});
        directed.push_back('{mk(OP_BIN, BI_MOD, 1, 1, SMIN, ONES), 1, none});
        directed.push_back('{mk(OP_BIN, BI_DIV, 0, 0, 7, '0), 1, '{'0, ST_DIVZERO, 0}});
        directed.push_back('{mk(OP_BIN, BI_MOD, 1, 1, -7, 2), 0, none});
        directed.push_back('{mk(OP_BIN, BI_DIV, 1, 1, -7, 2), 0, none});
        directed.push_back('{mk(OP_BIN, BI_MUL, 0, 0, ONES, ONES), 1, '{64'd1, ST_OK, 0}});
        directed.push_back('{mk(OP_BIN, BI_SHL, 0, 0, 1, 64), 1, none});
        directed.push_back('{mk(OP_BIN, BI_SHR, 1, 1, SMIN, ONES), 1, '{ONES, ST_OK, 0}});
        directed.push_back('{mk(OP_BIN, BI_SHR, 1, 1, SMIN, 4), 0, none});
        directed.push_back('{mk(OP_BIN, 4'd15, 0, 1, 1, 1), 1, '{'0, ST_UNSUP, 0}});
        directed.push_back('{mk(OP_BIN, BI_ADD, 0, 1, 1, 1), 1, '{'0, ST_TYPE, 0}});
        // False compare skips the next, a compare included.
        directed.push_back('{mk(OP_CMP, CMP_LT, 1, 1, 1, ONES), 1, none});
        directed.push_back('{mk(OP_CMP, CMP_EQ, 0, 0, 0, 0), 1, '{'0, ST_SKIPPED, 0}});
        // True compare runs the next and skips the one after.
        directed.push_back('{mk(OP_CMP, CMP_GE, 0, 0, ONES, 0), 1, '{'0, ST_OK, 1}});
        directed.push_back('{mk(OP_BIN, BI_XOR, 0, 0, ONES, 1), 0, none});
        directed.push_back('{mk(OP_BIN, BI_OR, 0, 0, 1, 2), 1, '{'0, ST_SKIPPED, 0}});
        // An error clears a pending skip.
        directed.push_back('{mk(OP_CMP, CMP_EQ, 1, 1, 1, 1), 1, '{'0, ST_OK, 1}});
        directed.push_back('{mk(OP_CMP, 4'd6, 1, 1, 1, 1), 1, '{'0, ST_UNSUP, 0}});
        directed.push_back('{mk(OP_CMP, 4'd6, 0, 0, 1, 1), 1, '{'0, ST_UNSUP, 0}});

        foreach (directed[k])
            send_beat(directed[k].ins, directed[k].check, directed[k].res);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            quiet_phase = (n > N_RANDOM - 150);
            send_beat(rand_instr(), 0, none);
        end
        in_ch.valid <= 1'b0;
        stim_done = 1;
    end

    // Receiver: random stalls, one long hold-off, none at the end.
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_off && sent_count >= 100)
            begin
                hold_off = 1;
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 15) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= quiet_phase || ($urandom_range(0, 3) != 0);
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                e = awaited_results.pop_front();
                if (out_ch.result_value !== e.result_value)
                begin
                    $error("result_value expected %h actual %h",
                           e.result_value, out_ch.result_value);
                    fail_count++;
                end
                if (out_ch.status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, out_ch.status);
                    fail_count++;
                end
                if (out_ch.cond_true !== e.cond_true)
                begin
                    $error("cond_true expected %0b actual %0b",
                           e.cond_true, out_ch.cond_true);
                    fail_count++;
                end
            end
        end
    end

    // Drain, settle and report.
    initial
    begin
        wait (stim_done);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
hdl/tacs_pkg.sv
hdl/tacs_in_if.sv
hdl/tacs_out_if.sv
hdl/tacs_datapath.sv
hdl/tacs_ctrl.sv
hdl/typed_alu_with_condition_skip.sv
verif/tb_tacs_channels.sv
verif/tb.sv
